@@ sv/bblru_pkg.sv @@
// ============================================================================
// bblru_pkg - shared types and constants for the byte budget LRU table
// Widths, reset values, cell commands, entry layout and engine states.
// ============================================================================
`default_nettype none

package bblru_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 64;

    localparam int KEY_W     = 64;
    localparam int SIZE_W    = 17;
    localparam int CAP_W     = 21;
    localparam int TOTAL_W   = 22;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int REG_IDX_W = 1;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET   = CAP_W'(1049000);
    localparam logic [SIZE_W-1:0] MAX_OBJECT_RESET = SIZE_W'(102400);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CAPACITY = 1'b0,
        REG_MAX_OBJ  = 1'b1
    } reg_idx_t;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_CLEAR
    } cell_cmd_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   size;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EVICT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/bblru_ifs.sv @@
// ============================================================================
// bblru channel interfaces
// Request and response channels with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface bblru_req_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [bblru_pkg::KEY_W-1:0]     key;
    logic [bblru_pkg::SIZE_W-1:0]    obj_bytes;

    modport source (output valid, output action, output key, output obj_bytes,
                    input ready);
    modport sink   (input valid, input action, input key, input obj_bytes,
                    output ready);
endinterface

interface bblru_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [bblru_pkg::SIZE_W-1:0]    hit_size;
    logic                            stored;
    logic [bblru_pkg::CNT_W-1:0]     evicted_count;
    logic [bblru_pkg::TOTAL_W-1:0]   bytes_in_use;

    modport source (output valid, output hit, output hit_size, output stored,
                    output evicted_count, output bytes_in_use, input ready);
    modport sink   (input valid, input hit, input hit_size, input stored,
                    input evicted_count, input bytes_in_use, output ready);
endinterface

`default_nettype wire

@@ sv/bblru_cell.sv @@
// ============================================================================
// bblru_cell - one slot of the recency chain
// Holds one entry; loads from either neighbor, holds, or drops its entry.
// ============================================================================
`default_nettype none

module bblru_cell (
    input  wire                                clk,
    input  wire                                rst_n,
    input  bblru_pkg::cell_cmd_t               cmd,
    input  bblru_pkg::entry_t                  prev_entry,
    input  bblru_pkg::entry_t                  next_entry,
    input  wire [bblru_pkg::KEY_BITS-1:0]      req_key,
    output bblru_pkg::entry_t                  entry,
    output logic                               match
);

    logic                              valid_reg, valid_next;
    logic [bblru_pkg::KEY_BITS-1:0]    key_reg, key_next;
    logic [bblru_pkg::SIZE_W-1:0]      size_reg, size_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        case (cmd)
            bblru_pkg::CELL_HOLD:
            begin
                valid_next = valid_reg;
            end
            bblru_pkg::CELL_FROM_PREV:
            begin
                valid_next = prev_entry.valid;
                key_next   = prev_entry.key;
                size_next  = prev_entry.size;
            end
            bblru_pkg::CELL_FROM_NEXT:
            begin
                valid_next = next_entry.valid;
                key_next   = next_entry.key;
                size_next  = next_entry.size;
            end
            bblru_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload only means something under valid
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        size_reg <= size_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.size  = size_reg;
    assign match       = valid_reg && (key_reg == req_key);

endmodule

`default_nettype wire

@@ sv/byte_budget_lru_cache_table.sv @@
// ============================================================================
// byte_budget_lru_cache_table - size bounded LRU table with a byte budget
// A chain of cells kept in recency order (cell 0 most recent) with a
// running byte total; lookups move hits to the front, inserts evict from
// the tail until the new object fits and then enter at the front.
// ============================================================================
//
//  channel  dir  handshake          contents
//  -------  ---  -----------------  -----------------------------------------
//  req      in   valid/ready        action, key, obj_bytes
//  rsp      out  valid/ready        hit, hit_size, stored, evicted_count,
//                                   bytes_in_use
//  cfg      in   cfg_we (no stall)  cfg_index, cfg_wdata
//
//  Lookup: accept, match, result. Insert: accept, match, the tail eviction
//  loop in the engine (one pass per evicted entry, a last pass stores),
//  result; a refused insert goes from match straight to result.
//  Valid entries always occupy cells 0..count-1, so the tail is found from
//  the valid bits alone. Reset empties the table at once (valid bits in
//  flip-flops), no clearing pass. A result waits in the output register; the
//  engine takes the next request meanwhile and stalls only at its own result.
//
`default_nettype none

module byte_budget_lru_cache_table (
    input  wire                                 clk,
    input  wire                                 rst_n,
    bblru_req_if.sink                           req,
    bblru_rsp_if.source                         rsp,
    input  wire                                 cfg_we,
    input  wire [bblru_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire [bblru_pkg::CAP_W-1:0]          cfg_wdata
);

    localparam int N     = bblru_pkg::ENTRIES;
    localparam int KB    = bblru_pkg::KEY_BITS;
    localparam int SW    = bblru_pkg::SIZE_W;
    localparam int TW    = bblru_pkg::TOTAL_W;
    localparam int CW    = bblru_pkg::CNT_W;
    localparam int CAPW  = bblru_pkg::CAP_W;

    // ---------------------------------------------------------------- state
    bblru_pkg::state_t         state_reg, state_next;

    // latched request
    logic                      req_action_reg, req_action_next;
    logic [KB-1:0]             req_key_reg, req_key_next;
    logic [SW-1:0]             req_size_reg, req_size_next;

    // configuration
    logic [CAPW-1:0]           capacity_reg;
    logic [SW-1:0]             max_obj_reg;

    // running byte total
    logic [TW-1:0]             total_reg, total_next;

    // result being built
    logic                      res_hit_reg, res_hit_next;
    logic [SW-1:0]             res_hit_size_reg, res_hit_size_next;
    logic                      res_stored_reg, res_stored_next;
    logic [CW-1:0]             res_evicted_reg, res_evicted_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic                      out_hit_reg, out_hit_next;
    logic [SW-1:0]             out_hit_size_reg, out_hit_size_next;
    logic                      out_stored_reg, out_stored_next;
    logic [CW-1:0]             out_evicted_reg, out_evicted_next;
    logic [TW-1:0]             out_total_reg, out_total_next;

    // ---------------------------------------------------------------- chain
    bblru_pkg::entry_t         cell_entry [N];
    bblru_pkg::cell_cmd_t      cell_cmd   [N];
    bblru_pkg::entry_t         front_entry;
    bblru_pkg::entry_t         empty_entry;
    logic [N-1:0]              cell_match;
    logic [N-1:0]              cell_valid;
    logic [N-1:0]              tail_mask;
    logic [N-1:0]              at_or_after_hit;   // cell index >= hit position
    logic [N-1:0]              at_or_before_hit;  // cell index <= hit position
    logic                      any_match;
    logic [SW-1:0]             hit_size_sel;
    logic [SW-1:0]             tail_size;
    logic                      table_full;
    logic                      table_empty;
    logic [TW:0]               fit_sum;
    logic                      need_evict;
    logic                      size_ok;
    logic                      req_fire;
    logic                      out_free;

    assign empty_entry = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        bblru_pkg::entry_t prev_e;
        bblru_pkg::entry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = front_entry;
        end
        else
        begin : g_mid_prev
            assign prev_e = cell_entry[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign next_e = empty_entry;
        end
        else
        begin : g_mid_next
            assign next_e = cell_entry[i+1];
        end

        bblru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cell_cmd[i]),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .req_key    (req_key_reg),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );

        assign cell_valid[i] = cell_entry[i].valid;
    end

    // tail = last valid cell; valid cells are packed from the front
    assign tail_mask   = cell_valid & ~(cell_valid >> 1);
    assign table_full  = cell_valid[N-1];
    assign table_empty = !cell_valid[0];
    assign any_match   = |cell_match;

    always_comb
    begin
        logic run_lo;
        logic run_hi;
        hit_size_sel = '0;
        tail_size    = '0;
        run_lo       = 1'b0;
        run_hi       = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            hit_size_sel = hit_size_sel | (cell_match[i] ? cell_entry[i].size : '0);
            tail_size    = tail_size | (tail_mask[i] ? cell_entry[i].size : '0);
            run_lo       = run_lo | cell_match[i];
            at_or_after_hit[i] = run_lo;
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            run_hi = run_hi | cell_match[i];
            at_or_before_hit[i] = run_hi;
        end
    end

    // evict while the table is full or the new size would overrun the budget
    assign fit_sum    = {1'b0, total_reg} + {{(TW + 1 - SW){1'b0}}, req_size_reg};
    assign need_evict = !table_empty &&
                        (table_full || (fit_sum > {{(TW + 1 - CAPW){1'b0}}, capacity_reg}));
    assign size_ok    = (req_size_reg <= max_obj_reg);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    // ---------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bblru_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = bblru_pkg::S_MATCH;
                end
            end
            bblru_pkg::S_MATCH:
            begin
                if (req_action_reg == bblru_pkg::ACT_INSERT && size_ok)
                begin
                    state_next = bblru_pkg::S_EVICT;
                end
                else
                begin
                    state_next = bblru_pkg::S_DONE;
                end
            end
            bblru_pkg::S_EVICT:
            begin
                if (!need_evict)
                begin
                    state_next = bblru_pkg::S_DONE;
                end
            end
            bblru_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bblru_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bblru_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------- datapath
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cell_cmd[i] = bblru_pkg::CELL_HOLD;
        end
        front_entry.valid = 1'b1;
        front_entry.key   = req_key_reg;
        front_entry.size  = req_size_reg;

        req_action_next   = req_action_reg;
        req_key_next      = req_key_reg;
        req_size_next     = req_size_reg;
        total_next        = total_reg;
        res_hit_next      = res_hit_reg;
        res_hit_size_next = res_hit_size_reg;
        res_stored_next   = res_stored_reg;
        res_evicted_next  = res_evicted_reg;

        out_valid_next    = out_valid_reg && !rsp.ready;
        out_hit_next      = out_hit_reg;
        out_hit_size_next = out_hit_size_reg;
        out_stored_next   = out_stored_reg;
        out_evicted_next  = out_evicted_reg;
        out_total_next    = out_total_reg;

        case (state_reg)
            bblru_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    req_action_next  = req.action;
                    req_key_next     = req.key[KB-1:0];
                    req_size_next    = req.obj_bytes;
                    res_evicted_next = '0;
                    res_hit_next     = 1'b0;
                    res_hit_size_next = '0;
                    res_stored_next  = 1'b0;
                end
            end
            bblru_pkg::S_MATCH:
            begin
                if (req_action_reg == bblru_pkg::ACT_LOOKUP)
                begin
                    res_hit_next      = any_match;
                    res_hit_size_next = hit_size_sel;
                    // move to front: cells up to the hit take from their left
                    if (any_match)
                    begin
                        front_entry.size = hit_size_sel;
                        for (int i = 0; i < N; i++)
                        begin
                            if (at_or_before_hit[i])
                            begin
                                cell_cmd[i] = bblru_pkg::CELL_FROM_PREV;
                            end
                        end
                    end
                end
                else if (size_ok && any_match)
                begin
                    // same key: close the gap, release its bytes
                    total_next = total_reg - {{(TW - SW){1'b0}}, hit_size_sel};
                    for (int i = 0; i < N; i++)
                    begin
                        if (at_or_after_hit[i])
                        begin
                            cell_cmd[i] = bblru_pkg::CELL_FROM_NEXT;
                        end
                    end
                end
            end
            bblru_pkg::S_EVICT:
            begin
                if (need_evict)
                begin
                    total_next       = total_reg - {{(TW - SW){1'b0}}, tail_size};
                    res_evicted_next = res_evicted_reg + CW'(1);
                    for (int i = 0; i < N; i++)
                    begin
                        if (tail_mask[i])
                        begin
                            cell_cmd[i] = bblru_pkg::CELL_CLEAR;
                        end
                    end
                end
                else
                begin
                    total_next      = total_reg + {{(TW - SW){1'b0}}, req_size_reg};
                    res_stored_next = 1'b1;
                    for (int i = 0; i < N; i++)
                    begin
                        cell_cmd[i] = bblru_pkg::CELL_FROM_PREV;
                    end
                end
            end
            bblru_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_hit_next      = res_hit_reg;
                    out_hit_size_next = res_hit_size_reg;
                    out_stored_next   = res_stored_reg;
                    out_evicted_next  = res_evicted_reg;
                    out_total_next    = total_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !rsp.ready;
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bblru_pkg::S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bblru_pkg::CAPACITY_RESET;
            max_obj_reg  <= bblru_pkg::MAX_OBJECT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bblru_pkg::REG_CAPACITY: capacity_reg <= cfg_wdata;
                bblru_pkg::REG_MAX_OBJ:  max_obj_reg  <= cfg_wdata[SW-1:0];
                default:                 capacity_reg <= capacity_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        req_action_reg    <= req_action_next;
        req_key_reg       <= req_key_next;
        req_size_reg      <= req_size_next;
        res_hit_reg       <= res_hit_next;
        res_hit_size_reg  <= res_hit_size_next;
        res_stored_reg    <= res_stored_next;
        res_evicted_reg   <= res_evicted_next;
        out_hit_reg       <= out_hit_next;
        out_hit_size_reg  <= out_hit_size_next;
        out_stored_reg    <= out_stored_next;
        out_evicted_reg   <= out_evicted_next;
        out_total_reg     <= out_total_next;
    end

    // -------------------------------------------------------------- ports
    assign req.ready         = (state_reg == bblru_pkg::S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.hit_size      = out_hit_size_reg;
    assign rsp.stored        = out_stored_reg;
    assign rsp.evicted_count = out_evicted_reg;
    assign rsp.bytes_in_use  = out_total_reg;

`ifndef ASSERT_OFF
    // valid cells stay packed at the front of the chain
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + N'(1)) & cell_valid) == '0)
        else $error("valid cells not contiguous");

    // keys are unique, so at most one cell matches
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bblru_pkg::S_MATCH) |-> $onehot0(cell_match))
        else $error("duplicate key in chain");

    // an empty table holds no bytes
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        table_empty |-> (total_reg == '0))
        else $error("byte total nonzero on empty table");

    // eviction loop ends once the table is empty
    a_evict_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bblru_pkg::S_EVICT && table_empty) |=>
        (state_reg != bblru_pkg::S_EVICT))
        else $error("eviction loop on empty table");

    // a lookup hit never reports a store or evictions
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (!rsp.stored && rsp.evicted_count == '0))
        else $error("hit result carries insert fields");
`endif

endmodule

`default_nettype wire

@@ tb/lru_table_monitor.sv @@
// ============================================================================
// lru_table_monitor - request/response monitor for the byte budget LRU table
// Watches the request, response and register write ports, keeps its own
// model of the recency table, and checks each response field against the
// oldest predicted outcome.
// ============================================================================

module lru_table_monitor
    import bblru_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    bblru_req_if                 req,
    bblru_rsp_if                 rsp,
    input  wire                  cfg_we,
    input  wire [REG_IDX_W-1:0]  cfg_index,
    input  wire [CAP_W-1:0]      cfg_wdata,
    output int                   fail_count,
    output int                   outstanding,
    output int                   results_seen,
    output int                   hit_total,
    output int                   store_total,
    output int                   evict_total
);

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

    typedef struct packed {
        logic               hit;
        logic [SIZE_W-1:0]  hit_size;
        logic               stored;
        logic [CNT_W-1:0]   evicted_count;
        logic [TOTAL_W-1:0] bytes_in_use;
    } table_outcome_t;

    // model of the table; rank 0 = most recent
    bit               line_valid [ENTRIES];
    logic [KEY_W-1:0] line_key   [ENTRIES];
    int unsigned      line_size  [ENTRIES];
    int unsigned      line_rank  [ENTRIES];
    int unsigned      bytes_held;
    int unsigned      capacity;
    int unsigned      max_object;

    table_outcome_t   predicted_outcomes [$];
    int               mismatches;
    int               compared;
    int               hits_seen;
    int               stores_seen;
    int               evictions_seen;

    function automatic int find_line(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && line_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int free_line();
        for (int i = 0; i < ENTRIES; i++)
            if (!line_valid[i])
                return i;
        return -1;
    endfunction

    function automatic int oldest_line();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && (best < 0 || line_rank[i] > line_rank[best]))
                best = i;
        return best;
    endfunction

    // remove a line, release its bytes, close the rank gap
    function automatic void drop_line(int idx);
        int unsigned r;
        r = line_rank[idx];
        line_valid[idx] = 1'b0;
        bytes_held -= line_size[idx];
        for (int j = 0; j < ENTRIES; j++)
            if (line_valid[j] && line_rank[j] > r)
                line_rank[j]--;
    endfunction

    function automatic table_outcome_t predict_table_op(action_t act,
                                                         logic [KEY_W-1:0] key_in,
                                                         logic [SIZE_W-1:0] size_in);
        table_outcome_t res;
        logic [KEY_W-1:0] k;
        int unsigned sz;
        int unsigned r;
        int idx;
        int victim;
        int evicted;
        bit done;
        res = '0;
        k = key_in & KEY_MASK;
        sz = size_in;
        evicted = 0;
        if (act == ACT_LOOKUP)
        begin
            idx = find_line(k);
            if (idx >= 0)
            begin
                r = line_rank[idx];
                res.hit = 1'b1;
                res.hit_size = SIZE_W'(line_size[idx]);
                for (int j = 0; j < ENTRIES; j++)
                    if (line_valid[j] && line_rank[j] < r)
                        line_rank[j]++;
                line_rank[idx] = 0;
            end
        end
        else if (sz <= max_object)
        begin
            idx = find_line(k);
            if (idx >= 0)
                drop_line(idx);
            done = 1'b0;
            while (!done)
            begin
                if (free_line() >= 0 && bytes_held + sz <= capacity)
                    done = 1'b1;
                else
                begin
                    victim = oldest_line();
                    if (victim < 0)
                        done = 1'b1;
                    else
                    begin
                        drop_line(victim);
                        evicted++;
                    end
                end
            end
            idx = free_line();
            if (idx >= 0)
            begin
                for (int j = 0; j < ENTRIES; j++)
                    if (line_valid[j])
                        line_rank[j]++;
                line_valid[idx] = 1'b1;
                line_key[idx] = k;
                line_size[idx] = sz;
                line_rank[idx] = 0;
                bytes_held += sz;
                res.stored = 1'b1;
            end
        end
        res.evicted_count = CNT_W'(evicted);
        res.bytes_in_use = TOTAL_W'(bytes_held);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_valid[i] = 1'b0;
                line_rank[i] = 0;
            end
            bytes_held = 0;
            capacity = CAPACITY_RESET;
            max_object = MAX_OBJECT_RESET;
            predicted_outcomes.delete();
            mismatches = 0;
            compared = 0;
            hits_seen = 0;
            stores_seen = 0;
            evictions_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CAPACITY: capacity = cfg_wdata;
                    REG_MAX_OBJ:  max_object = cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // compare before predicting: a response never belongs to the
            // request taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    $error("response with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    compared++;
                    hits_seen += want.hit;
                    stores_seen += want.stored;
                    evictions_seen += want.evicted_count;
                    if (rsp.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
                        mismatches++;
                    end
                    if (rsp.hit_size !== want.hit_size)
                    begin
                        $error("hit_size: expected %0d, got %0d", want.hit_size, rsp.hit_size);
                        mismatches++;
                    end
                    if (rsp.stored !== want.stored)
                    begin
                        $error("stored: expected %0d, got %0d", want.stored, rsp.stored);
                        mismatches++;
                    end
                    if (rsp.evicted_count !== want.evicted_count)
                    begin
                        $error("evicted_count: expected %0d, got %0d",
                               want.evicted_count, rsp.evicted_count);
                        mismatches++;
                    end
                    if (rsp.bytes_in_use !== want.bytes_in_use)
                    begin
                        $error("bytes_in_use: expected %0d, got %0d",
                               want.bytes_in_use, rsp.bytes_in_use);
                        mismatches++;
                    end
                end
            end

            if (req.valid && req.ready)
                predicted_outcomes.push_back(predict_table_op(action_t'(req.action),
                                                              req.key, req.obj_bytes));
        end

        fail_count   <= mismatches;
        outstanding  <= predicted_outcomes.size();
        results_seen <= compared;
        hit_total    <= hits_seen;
        store_total  <= stores_seen;
        evict_total  <= evictions_seen;
    end

endmodule

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top - testbench for byte_budget_lru_cache_table
// Drives lookup and insert requests in bursts under a changing register
// setup, stalls the response side on shifting patterns, and leaves all
// checking to lru_table_monitor; this module only gives the verdict.
// ============================================================================

module tb_top;

    import bblru_pkg::*;

    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 228;
    localparam int POOL           = 24;
    localparam int LONG_STALL     = 300;
    localparam int STALL_AFTER    = 400;   // requests sent before the long hold-off
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SIZE_TOP       = (1 << SIZE_W) - 1;

    // register setup per phase; phase 0 runs on the reset values
    localparam int unsigned PHASE_CAP [PHASES] =
        '{CAPACITY_RESET, 2097151, 0, 300000, 120000, 1049000, 65536, 2097151};
    localparam int unsigned PHASE_MAX [PHASES] =
        '{MAX_OBJECT_RESET, 131071, 131071, 50000, 131071, 0, 4096, 1000};

    typedef enum {
        DRAIN_FREE,     // always ready
        DRAIN_COIN,     // ready half the time
        DRAIN_SPARSE,   // ready a quarter of the time
        DRAIN_COMB      // fixed repeating pattern, ready two thirds of the time
    } drain_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CAP_W-1:0]     cfg_wdata;

    int fail_count;
    int outstanding;
    int results_seen;
    int hit_total;
    int store_total;
    int evict_total;

    // stimulus bookkeeping
    logic [KEY_W-1:0] key_pool [POOL];
    int unsigned      cur_max;
    int               burst_left;
    int               sent_count;
    int               idle_cycles = 0;

    bblru_req_if req_ch ();
    bblru_rsp_if rsp_ch ();

    byte_budget_lru_cache_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lru_table_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .hit_total    (hit_total),
        .store_total  (store_total),
        .evict_total  (evict_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the table takes it. Valid is
    // left high on return so back-to-back requests keep the port busy;
    // a gap is opened only when the current burst runs out.
    task automatic issue(action_t act, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] sz);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.key       <= k;
        req_ch.obj_bytes <= sz;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Stop offering and wait until every predicted response has come back.
    // Each request yields a response, so the table is idle at that point;
    // the spare cycles that follow cover the result register draining.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Both registers are written back to back; junk goes into the upper
    // write-data bits of the 17-bit register, which the table must drop.
    task automatic set_config(int unsigned cap, int unsigned max_obj);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_wdata <= CAP_W'(cap);
        @(posedge clk);
        cfg_index <= REG_MAX_OBJ;
        cfg_wdata <= {(CAP_W - SIZE_W)'($urandom), SIZE_W'(max_obj)};
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_max = max_obj;
    endtask

    // Size mix: zero, exactly the limit, one past it, fully random (often
    // refused), anything allowed, and small objects so the table fills up.
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned lim;
        lim = cur_max;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SIZE_W'(lim);
            2:       return SIZE_W'((lim < SIZE_TOP) ? lim + 1 : lim);
            3:       return SIZE_W'($urandom);
            4, 5:    return SIZE_W'($urandom_range(0, lim));
            default: return SIZE_W'($urandom_range(0, lim / 16));
        endcase
    endfunction

    initial
    begin : stimulus
        int p;
        int n;
        action_t act;
        logic [KEY_W-1:0] k;

        req_ch.valid     <= 1'b0;
        req_ch.action    <= ACT_LOOKUP;
        req_ch.key       <= '0;
        req_ch.obj_bytes <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_CAPACITY;
        cfg_wdata        <= '0;
        rst_n            <= 1'b0;
        burst_left = 0;
        sent_count = 0;
        cur_max = MAX_OBJECT_RESET;

        // pool is larger than the table, so pool keys both hit and get evicted
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < POOL; n++)
            key_pool[n] = {$urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed requests on the reset register values ---
        issue(ACT_LOOKUP, key_pool[0], '1);                          // miss on empty table
        issue(ACT_INSERT, key_pool[0], '0);                          // zero-byte object
        issue(ACT_INSERT, key_pool[1], MAX_OBJECT_RESET);            // exactly at the limit
        issue(ACT_INSERT, 64'h5A5A_5A5A_5A5A_5A5A,
              SIZE_W'(MAX_OBJECT_RESET + 1));                        // refused
        issue(ACT_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, '1);              // refused, largest size
        issue(ACT_LOOKUP, key_pool[1], '1);                          // hit, size ignored
        issue(ACT_LOOKUP, key_pool[0], '0);                          // hit on zero size
        issue(ACT_INSERT, key_pool[1], 17'd5);                       // same key replaced
        // byte budget overflows around the eleventh of these
        for (n = 0; n < 12; n++)
            issue(ACT_INSERT, KEY_W'(64'h100 + n), 17'd100000);
        issue(ACT_LOOKUP, key_pool[0], '0);
        issue(ACT_LOOKUP, KEY_W'(64'h10B), '0);
        settle();

        // --- random phases, one register setting each ---
        // Capacity drops from phase to phase leave entries above budget
        // until the next insert; capacity zero and small budgets with large
        // objects exercise the store-anyway case; tiny objects under a wide
        // budget run the table full so it evicts for lack of slots.
        for (p = 0; p < PHASES; p++)
        begin
            if (p != 0)
                set_config(PHASE_CAP[p], PHASE_MAX[p]);
            for (n = 0; n < 4; n++)
                key_pool[$urandom_range(2, POOL - 1)] = {$urandom, $urandom};
            for (n = 0; n < PHASE_REQUESTS; n++)
            begin
                act = ($urandom_range(0, 99) < 45) ? ACT_LOOKUP : ACT_INSERT;
                k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL - 1)]
                                               : {$urandom, $urandom};
                issue(act, k, pick_size());
            end
            settle();
        end

        // let any late response surface before the verdict
        repeat (24) @(posedge clk);

        $display("Run covered %0d requests over %0d register settings, %0d responses checked.",
                 sent_count, PHASES, results_seen);
        $display("Outcomes: %0d lookup hits, %0d inserts stored, %0d entries evicted.",
                 hit_total, store_total, evict_total);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: ready follows a mode that changes at random. Once,
    // after enough requests have gone in, ready is held low for a long
    // stretch so the result register and the engine back up and the
    // request port stalls while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin : response_drain
        drain_mode_t mode;
        int span;
        int tick;
        bit long_stall_done;

        rsp_ch.ready <= 1'b0;
        mode = DRAIN_FREE;
        span = 0;
        tick = 0;
        long_stall_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_stall_done && sent_count >= STALL_AFTER)
            begin
                long_stall_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = drain_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(10, 80);
                end
                span--;
                tick++;
                case (mode)
                    DRAIN_FREE:   rsp_ch.ready <= 1'b1;
                    DRAIN_COIN:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    DRAIN_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:      rsp_ch.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no request or response moving for too long means the
    // table hung. The limit sits well above the long hold-off plus the
    // slowest insert (a full sweep of evictions).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ files.f @@
sv/bblru_pkg.sv
sv/bblru_ifs.sv
sv/bblru_cell.sv
sv/byte_budget_lru_cache_table.sv
tb/lru_table_monitor.sv
tb/tb_top.sv
